// ===== rtl/spd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types and constants for the strum peak detector.
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int MIDRAIL_BITS  = 10;
  localparam int NOISE_BITS    = 9;
  localparam int DELTA_BITS    = 10;
  localparam int COUNT_BITS    = 16;
  localparam int STRENGTH_BITS = 10;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int HIST_DEPTH    = 5;

  localparam logic [MIDRAIL_BITS-1:0] MIDRAIL_RST     = 10'd512;
  localparam logic [NOISE_BITS-1:0]   NOISE_RST       = 9'd150;
  localparam logic [DELTA_BITS-1:0]   DELTA_RST       = 10'd10;
  localparam logic [COUNT_BITS-1:0]   MIN_SAMPLES_RST = 16'd256;

  // x / 5 == (x * RECIP_5) >> RECIP_SHIFT for any x below 2^32
  localparam logic [31:0] RECIP_5     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 34;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIDRAIL     = 2'd0,
    REG_NOISE_BAND  = 2'd1,
    REG_MIN_DELTA   = 2'd2,
    REG_MIN_SAMPLES = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [MIDRAIL_BITS-1:0] midrail;
    logic [NOISE_BITS-1:0]   noise_band;
    logic [DELTA_BITS-1:0]   min_delta;
    logic [COUNT_BITS-1:0]   min_samples;
  } cfg_t;

  typedef struct packed {
    logic                     strum;
    logic [STRENGTH_BITS-1:0] strength;
    logic                     armed;
  } result_t;

endpackage

// ===== rtl/strum_peak_detector_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strum_peak_detector_top
// Strum detection on a stream of converter samples, one result per sample.
// ----------------------------------------------------------------------------
//   channel | dir | payload
//   in_     | in  | tdata: sample
//   out_    | out | tdata: strength, armed; tuser: strum
//   cfg_    | in  | write enable, register index, data
//
// One sample per cycle sustained while the output is not stalled; a sample is
// taken into the input register and the detect pass then lands its result in
// the result register, which drives out_tvalid and the output payload.
// The path is set by the peak sum times the reciprocal of five and the level
// compare. Reset is synchronous; the histories start at midrail.
// A stalled output holds its beat; the input register still takes one more.
// ----------------------------------------------------------------------------
module strum_peak_detector_top
  import spd_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
)(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,   // [SAMPLE_BITS-1:0] sample
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [15:0]              out_tdata,  // [9:0] strength, [10] armed
  output logic                     out_tuser,  // [0] strum
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t    cfg;
  result_t res;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_res_r;
  logic                   advance, fire, in_beat;

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  spd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spd_detect #(.SAMPLE_BITS(SAMPLE_BITS)) u_detect (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (fire),
    .sample (s1_sample_r),
    .res    (res)
  );

  always_comb begin
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = advance ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) s1_sample_r <= in_tdata[SAMPLE_BITS-1:0];
    if (fire)    out_res_r   <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.strum;
  assign out_tdata  = {5'b0, out_res_r.armed, out_res_r.strength};

  // strength only carries a level on a strum beat
  a_strength_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[STRENGTH_BITS-1:0] == '0)
    else $error("strength set on a non-strum beat");

  // a held output with a sample waiting must block the input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && s1_valid_r |-> !in_tready)
    else $error("input taken while both stages are full");

  // a detect pass always lands in the result register
  a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("detect pass lost its result");

endmodule

// ===== rtl/spd_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_cfg_regs
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module spd_cfg_regs
  import spd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output cfg_t                     cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_MIDRAIL:     cfg_nxt.midrail     = cfg_wdata[MIDRAIL_BITS-1:0];
        REG_NOISE_BAND:  cfg_nxt.noise_band  = cfg_wdata[NOISE_BITS-1:0];
        REG_MIN_DELTA:   cfg_nxt.min_delta   = cfg_wdata[DELTA_BITS-1:0];
        REG_MIN_SAMPLES: cfg_nxt.min_samples = cfg_wdata[COUNT_BITS-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.midrail     <= MIDRAIL_RST;
      cfg_r.noise_band  <= NOISE_RST;
      cfg_r.min_delta   <= DELTA_RST;
      cfg_r.min_samples <= MIN_SAMPLES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/spd_detect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_detect
// Detection state (peak history, level base, counter, arm flag) and the
// single-pass classify / push / compare logic for one sample.
// ----------------------------------------------------------------------------
module spd_detect
  import spd_pkg::*;
#(
  parameter int SAMPLE_BITS = 10
)(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  logic                   fire,
  input  logic [SAMPLE_BITS-1:0] sample,
  output result_t                res
);

  // peaks hold samples or midrail; levels are at most one peak wide
  localparam int PW = (SAMPLE_BITS > MIDRAIL_BITS) ? SAMPLE_BITS : MIDRAIL_BITS;
  localparam int SW = PW + 3;          // sum of five peaks
  localparam int CW = PW + 2;          // band threshold compares
  localparam int MW = SW + 32;         // reciprocal product

  logic [PW-1:0]         peak_r [HIST_DEPTH];
  logic [PW-1:0]         peak_nxt [HIST_DEPTH];
  logic [SW-1:0]         peak_sum_r, peak_sum_nxt;
  // level history is always uniform after reset or a refill: one value holds it
  logic [PW-1:0]         level_base_r, level_base_nxt;
  logic [COUNT_BITS-1:0] since_r, since_nxt;
  logic                  armed_r, armed_nxt;

  logic [CW-1:0] s_x, mid_x, upper, lower;
  logic          out_of_band, positive, push_peak, push_level, strum;
  logic [MW-1:0] prod;
  logic [PW-1:0] level;
  logic [PW:0]   level_thr;
  logic [SW-1:0] mid5;
  logic [COUNT_BITS-1:0] since_inc;

  always_comb begin
    s_x   = CW'(sample);
    mid_x = CW'(cfg.midrail);
    upper = mid_x + CW'(cfg.noise_band);
    lower = mid_x - CW'(cfg.noise_band);
    out_of_band = (s_x >= upper) ||
                  ((cfg.midrail >= MIDRAIL_BITS'(cfg.noise_band)) && (s_x <= lower));
    positive   = (s_x >= mid_x);
    push_peak  = out_of_band && positive && (PW'(sample) > peak_r[0]);
    push_level = out_of_band && !positive && (peak_r[0] > PW'(cfg.midrail));

    prod      = MW'(peak_sum_r) * MW'(RECIP_5);
    level     = prod[RECIP_SHIFT +: PW];
    level_thr = (PW+1)'(level_base_r) + (PW+1)'(cfg.min_delta);
    strum     = push_level && armed_r && ((PW+1)'(level) > level_thr);

    mid5      = SW'({cfg.midrail, 2'b00}) + SW'(cfg.midrail);
    since_inc = (since_r != '1) ? since_r + 1'b1 : since_r;
  end

  always_comb begin
    for (int i = 0; i < HIST_DEPTH; i++) peak_nxt[i] = peak_r[i];
    peak_sum_nxt   = peak_sum_r;
    level_base_nxt = level_base_r;
    since_nxt      = strum ? '0 : since_inc;
    armed_nxt      = strum ? 1'b0 : armed_r;

    if (push_peak) begin
      for (int i = 1; i < HIST_DEPTH; i++) peak_nxt[i] = peak_r[i-1];
      peak_nxt[0]  = PW'(sample);
      peak_sum_nxt = peak_sum_r - SW'(peak_r[HIST_DEPTH-1]) + SW'(sample);
    end
    if (push_level) begin
      for (int i = 0; i < HIST_DEPTH; i++) peak_nxt[i] = PW'(cfg.midrail);
      peak_sum_nxt   = mid5;
      level_base_nxt = PW'(cfg.midrail);
    end
    if (out_of_band && (since_nxt >= cfg.min_samples)) armed_nxt = 1'b1;

    res.strum    = strum;
    res.strength = strum ? level[STRENGTH_BITS-1:0] : '0;
    res.armed    = armed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) peak_r[i] <= PW'(MIDRAIL_RST);
      peak_sum_r   <= SW'(HIST_DEPTH) * SW'(MIDRAIL_RST);
      level_base_r <= PW'(MIDRAIL_RST);
      since_r      <= '0;
      armed_r      <= 1'b1;
    end else if (fire) begin
      for (int i = 0; i < HIST_DEPTH; i++) peak_r[i] <= peak_nxt[i];
      peak_sum_r   <= peak_sum_nxt;
      level_base_r <= level_base_nxt;
      since_r      <= since_nxt;
      armed_r      <= armed_nxt;
    end
  end

endmodule
